FILE: hdl/rfbg_pkg.sv
package rfbg_pkg;

    localparam int MAX_CHIPS   = 4;
    localparam int WORD_W      = 16;
    localparam int INDEX_W     = 11;
    localparam int POS_W       = 4;
    localparam int GRAY_W      = 12;
    localparam int FIFO_DEPTH  = 2;

    localparam int OUT_DATA_W  = 80;
    localparam int OUT_USER_W  = 2;

    // tuser bit positions on the result side
    localparam int USER_ROLL_VALID    = 0;
    localparam int USER_ROLL_MISMATCH = 1;

    typedef logic [WORD_W-1:0] word_t;

    // one completed word per chip, classified by the front end
    typedef struct packed {
        word_t [MAX_CHIPS-1:0] chip;
        logic [INDEX_W-1:0]    index;
        logic                  is_sample;
        logic                  is_roll;
        logic                  is_last;
    } word_item_t;

endpackage

FILE: hdl/rfbg_front.sv
module rfbg_front
    import rfbg_pkg::*;
#(
    parameter int CHIPS        = 4,
    parameter int SAMPLE_WORDS = 1920,
    parameter int FRAME_WORDS  = 1924
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tuser,
    input  logic       fifo_full,
    output logic       push,
    output word_item_t push_item
);

    localparam int CNT_MAX = (SAMPLE_WORDS > FRAME_WORDS) ? SAMPLE_WORDS : FRAME_WORDS;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    logic [3:0]            bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]      word_cnt_reg, word_cnt_next;
    logic                  active_reg, active_next;
    word_t [MAX_CHIPS-1:0] shift_reg, shift_next;
    logic                  accept;
    logic                  word_done;
    logic [CNT_W+INDEX_W-1:0] index_ext;

    assign s_tready  = !fifo_full;
    assign accept    = s_tvalid && s_tready;
    assign word_done = accept && !s_tuser && active_reg && (bit_cnt_reg == 4'hf);
    assign push      = word_done;
    assign index_ext = (CNT_W + INDEX_W)'(word_cnt_reg);

    always_comb
    begin
        bit_cnt_next  = bit_cnt_reg;
        word_cnt_next = word_cnt_reg;
        active_next   = active_reg;
        shift_next    = shift_reg;
        if (accept)
        begin
            if (s_tuser)
            begin
                bit_cnt_next  = '0;
                word_cnt_next = '0;
                active_next   = 1'b1;
                shift_next    = '0;
            end
            else if (active_reg)
            begin
                for (int k = 0; k < MAX_CHIPS; k++)
                begin
                    if (k < CHIPS)
                        shift_next[k] = {shift_reg[k][WORD_W-2:0], s_tdata[3-k]};
                    else
                        shift_next[k] = '0;
                end
                bit_cnt_next = bit_cnt_reg + 4'd1;
                if (bit_cnt_reg == 4'hf)
                begin
                    word_cnt_next = word_cnt_reg + CNT_W'(1);
                    if (word_cnt_reg == CNT_W'(FRAME_WORDS - 1))
                        active_next = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < MAX_CHIPS; k++)
        begin
            if (k < CHIPS)
                push_item.chip[k] = shift_next[k];
            else
                push_item.chip[k] = '0;
        end
        push_item.index     = index_ext[INDEX_W-1:0];
        push_item.is_sample = (word_cnt_reg < CNT_W'(SAMPLE_WORDS));
        push_item.is_roll   = (word_cnt_reg == CNT_W'(SAMPLE_WORDS));
        push_item.is_last   = (word_cnt_reg == CNT_W'(FRAME_WORDS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg  <= '0;
            word_cnt_reg <= '0;
            active_reg   <= 1'b0;
            shift_reg    <= '0;
        end
        else
        begin
            bit_cnt_reg  <= bit_cnt_next;
            word_cnt_reg <= word_cnt_next;
            active_reg   <= active_next;
            shift_reg    <= shift_next;
        end
    end

endmodule

FILE: hdl/rfbg_fifo.sv
module rfbg_fifo
    import rfbg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  word_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       empty,
    output word_item_t head
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    word_item_t        mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full  = (count_reg == CNT_W'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
        end
    end

    // occupancy never runs past the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("queue occupancy beyond depth");

    // the front end must hold off when the queue is full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

    // the back end only pops a present entry
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    // a lone push raises occupancy by one
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("occupancy not tracking push");

endmodule

FILE: hdl/rfbg_back.sv
module rfbg_back
    import rfbg_pkg::*;
#(
    parameter int CHIPS     = 4,
    parameter int ROLL_BITS = 13
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  empty,
    input  word_item_t            head,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [OUT_USER_W-1:0] m_tuser,
    output logic                  m_tlast
);

    localparam logic [WORD_W-1:0] ROLL_MASK = WORD_W'((32'd1 << ROLL_BITS) - 32'd1);

    logic                  valid_reg;
    word_t [MAX_CHIPS-1:0] chip_reg, chip_next;
    logic [INDEX_W-1:0]    index_reg;
    logic                  roll_valid_reg;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic                  mism_reg, mism_next;
    logic                  last_reg;

    logic [WORD_W-1:0]     roll_m;
    logic [WORD_W-1:0]     roll_rest;
    logic [4:0]            hi_idx, nx_idx;
    logic                  hi_found, nx_found;
    logic [4:0]            hi_plus;

    assign pop = !empty && (!valid_reg || m_tready);

    // Gray to binary on the low 12 bits of sample words; trailer words pass raw
    always_comb
    begin
        for (int k = 0; k < MAX_CHIPS; k++)
        begin
            chip_next[k] = head.chip[k];
            if (head.is_sample)
            begin
                chip_next[k] = '0;
                chip_next[k][WORD_W-1] = head.chip[k][WORD_W-1];
                for (int i = 0; i < GRAY_W; i++)
                    chip_next[k][i] = ^(head.chip[k][GRAY_W-1:0] >> i);
            end
        end
    end

    // roll mask: highest and next highest set bit of the last chip's mask, and the chip-to-chip mismatch flag
    always_comb
    begin
        roll_m    = head.chip[CHIPS-1] & ROLL_MASK;
        hi_found  = 1'b0;
        hi_idx    = '0;
        for (int b = 0; b < WORD_W; b++)
        begin
            if (roll_m[b])
            begin
                hi_found = 1'b1;
                hi_idx   = 5'(b);
            end
        end
        roll_rest = roll_m;
        roll_rest[hi_idx[3:0]] = 1'b0;
        nx_found  = 1'b0;
        nx_idx    = '0;
        for (int b = 0; b < WORD_W; b++)
        begin
            if (roll_rest[b])
            begin
                nx_found = 1'b1;
                nx_idx   = 5'(b);
            end
        end
        hi_plus = hi_idx + 5'd1;
        if (hi_found && hi_idx == 5'(ROLL_BITS - 1) && nx_found && nx_idx == 5'(ROLL_BITS - 2))
            pos_next = '0;
        else if (hi_found && hi_idx == 5'(ROLL_BITS - 1) && nx_found && nx_idx == 5'd0)
            pos_next = POS_W'(1);
        else if (hi_found)
            pos_next = hi_plus[POS_W-1:0];
        else
            pos_next = '0;

        mism_next = 1'b0;
        for (int k = 1; k < MAX_CHIPS; k++)
        begin
            if (k < CHIPS && ((head.chip[k] & ROLL_MASK) != (head.chip[0] & ROLL_MASK)))
                mism_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            chip_reg       <= chip_next;
            index_reg      <= head.index;
            roll_valid_reg <= head.is_roll;
            pos_reg        <= head.is_roll ? pos_next : '0;
            mism_reg       <= head.is_roll && mism_next;
            last_reg       <= head.is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (m_tready)
            valid_reg <= 1'b0;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, pos_reg, chip_reg[3], chip_reg[2], chip_reg[1], chip_reg[0],
                       index_reg};
    assign m_tuser  = {mism_reg, roll_valid_reg};
    assign m_tlast  = last_reg;

endmodule

FILE: hdl/readout_frame_bitplane_gray_decoder.sv
// Readout frame decoder: takes the raw byte stream of a readout frame, one byte per
// transaction, and returns one transaction for every completed 16-bit word of all four
// chips. A byte with s_tuser set is the frame header; it is dropped and (re)starts the
// frame. Each following byte gives chip k its next bit (MSB first) in bit 3-k. Sample
// words keep bit 15 and carry the low 12 bits converted from Gray code to binary; the
// trailer words pass raw. On the first trailer word the roll mask is decoded into the
// cell of time sample 0 (from the last chip) and a chip-to-chip mismatch is flagged.
// Bytes outside a frame are swallowed. Rate: one byte per clock while the queue is not
// full; a result leaves for every 16 bytes, after passing through the two-entry queue
// between the bit-plane front end and the decode stage and then the output register.
// The front end stalls only when that queue is full.
module readout_frame_bitplane_gray_decoder
    import rfbg_pkg::*;
#(
    parameter int CHIPS        = 4,
    parameter int SAMPLE_WORDS = 1920,
    parameter int FRAME_WORDS  = 1924,
    parameter int ROLL_BITS    = 13
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // byte side
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tuser,   // [0] frame_start
    // word side
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [10:0] word_index, [26:11] chip0_word,
                                             // [42:27] chip1_word, [58:43] chip2_word,
                                             // [74:59] chip3_word, [78:75] sample0_cell,
                                             // [79] zero pad
    output logic [OUT_USER_W-1:0] m_tuser,   // [0] roll_valid, [1] roll_mismatch
    output logic                  m_tlast    // frame_last
);

    logic       fifo_full;
    logic       fifo_empty;
    logic       push;
    logic       pop;
    word_item_t push_item;
    word_item_t head;

    // front end: bit-plane shifting, word and frame counting, classification
    rfbg_front #(
        .CHIPS        (CHIPS),
        .SAMPLE_WORDS (SAMPLE_WORDS),
        .FRAME_WORDS  (FRAME_WORDS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .fifo_full (fifo_full),
        .push      (push),
        .push_item (push_item)
    );

    // short queue decoupling the two halves
    rfbg_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (pop),
        .empty     (fifo_empty),
        .head      (head)
    );

    // back end: Gray conversion, roll decode, output register
    rfbg_back #(
        .CHIPS     (CHIPS),
        .ROLL_BITS (ROLL_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (fifo_empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
